FILE: rtl/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
// No dependencies; imported by every module of the block.
package tgc_pkg;

   localparam int THR_W      = 11;
   localparam int LONG_W     = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_SWIPE_THRESHOLD = 1'b0,
      REG_LONG_PRESS      = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      GEST_NONE  = 3'd0,
      GEST_LONG  = 3'd1,
      GEST_LEFT  = 3'd2,
      GEST_RIGHT = 3'd3,
      GEST_TAP   = 3'd4
   } gesture_type;

   typedef struct packed {
      logic [THR_W-1:0]  swipe_threshold_px;
      logic [LONG_W-1:0] long_press_ms;
   } cfg_type;

endpackage

FILE: rtl/tgc_csr.sv
// Configuration registers of the touch gesture classifier, APB-style access.
// Depends on tgc_pkg.
module tgc_csr
   import tgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [LONG_W-1:0] long_ff, long_in;
   logic              wr_en;
   csr_reg_type       sel;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign sel        = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      thr_in     = thr_ff;
      long_in    = long_ff;
      csr_prdata = '0;
      unique case (sel)
         REG_SWIPE_THRESHOLD: begin
            csr_prdata = {{(CSR_DATA_W-THR_W){1'b0}}, thr_ff};
            if (wr_en) begin
               thr_in = csr_pwdata[THR_W-1:0];
            end
         end
         REG_LONG_PRESS: begin
            csr_prdata = {{(CSR_DATA_W-LONG_W){1'b0}}, long_ff};
            if (wr_en) begin
               long_in = csr_pwdata[LONG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_W'(40);
         long_ff <= LONG_W'(600);
      end else begin
         thr_ff  <= thr_in;
         long_ff <= long_in;
      end
   end

   assign cfg.swipe_threshold_px = thr_ff;
   assign cfg.long_press_ms      = long_ff;

endmodule

FILE: rtl/tgc_classify.sv
// Press tracking state and gesture decision for one touch sample.
// Depends on tgc_pkg.
module tgc_classify
   import tgc_pkg::*;
#(
   parameter int POS_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                touching,
   input  logic [TIME_W-1:0]   time_ms,
   input  logic [POS_BITS-1:0] pos_x,
   input  cfg_type             cfg,
   output gesture_type         gesture
);

   localparam int CMP_W = ((POS_BITS > THR_W) ? POS_BITS : THR_W) + 2;

   logic                held_ff, held_in;
   logic                long_done_ff, long_done_in;
   logic                travelled_ff, travelled_in;
   logic [TIME_W-1:0]   start_time_ff, start_time_in;
   logic [POS_BITS-1:0] start_pos_ff, start_pos_in;

   logic signed [CMP_W-1:0] d;
   logic signed [CMP_W-1:0] mag;
   logic signed [CMP_W-1:0] thr;
   logic [TIME_W-1:0]       elapsed;
   logic                    time_up;
   logic                    far;

   assign d   = signed'(CMP_W'(pos_x)) - signed'(CMP_W'(start_pos_ff));
   assign mag = (d < 0) ? -d : d;
   assign thr = signed'(CMP_W'(cfg.swipe_threshold_px));
   assign elapsed = time_ms - start_time_ff;
   assign time_up = elapsed >= TIME_W'(cfg.long_press_ms);
   assign far     = mag >= thr;

   always_comb begin
      held_in       = held_ff;
      long_done_in  = long_done_ff;
      travelled_in  = travelled_ff;
      start_time_in = start_time_ff;
      start_pos_in  = start_pos_ff;
      gesture       = GEST_NONE;
      if (touching) begin
         if (!held_ff) begin
            held_in       = 1'b1;
            start_time_in = time_ms;
            long_done_in  = 1'b0;
            start_pos_in  = pos_x;
            travelled_in  = 1'b0;
         end else begin
            if (far) begin
               travelled_in = 1'b1;
            end
            if (!long_done_ff && time_up && !far) begin
               long_done_in = 1'b1;
               gesture      = GEST_LONG;
            end
         end
      end else if (held_ff) begin
         if (!long_done_ff) begin
            if (d <= -thr) begin
               gesture = GEST_LEFT;
            end else if (d >= thr) begin
               gesture = GEST_RIGHT;
            end else if (!travelled_ff && !time_up) begin
               gesture = GEST_TAP;
            end
         end
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         long_done_ff  <= 1'b0;
         travelled_ff  <= 1'b0;
         start_time_ff <= '0;
         start_pos_ff  <= '0;
      end else if (step) begin
         held_ff       <= held_in;
         long_done_ff  <= long_done_in;
         travelled_ff  <= travelled_in;
         start_time_ff <= start_time_in;
         start_pos_ff  <= start_pos_in;
      end
   end

endmodule

FILE: rtl/touch_gesture_classifier.sv
// Touch gesture classifier: tap, long press and horizontal swipe detection.
// Path: an accepted item waits in the input register, then goes through the classifier into the result register.
// Throughput: one item per cycle unless rsp_stall holds a full result register; the press state updates as an item
// moves to the result register. Reset (synchronous): clears press state and both valid flags, thresholds return to
// 40 px / 600 ms. Depends on tgc_pkg, tgc_csr and tgc_classify.
module touch_gesture_classifier
   import tgc_pkg::*;
#(
   parameter int POS_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_touching,
   input  logic [TIME_W-1:0]     req_time_ms,
   input  logic [POS_BITS-1:0]   req_pos_x,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_gesture,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   logic                in_valid_ff;
   logic                in_touching_ff;
   logic [TIME_W-1:0]   in_time_ff;
   logic [POS_BITS-1:0] in_pos_ff;
   logic                out_valid_ff;
   gesture_type         out_gesture_ff;
   gesture_type         gesture;
   logic                out_ready;
   logic                step;

   tgc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tgc_classify #(
      .POS_BITS (POS_BITS)
   ) u_classify (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .touching (in_touching_ff),
      .time_ms  (in_time_ff),
      .pos_x    (in_pos_ff),
      .cfg      (cfg),
      .gesture  (gesture)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_touching_ff <= req_touching;
         in_time_ff     <= req_time_ms;
         in_pos_ff      <= req_pos_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_gesture_ff <= gesture;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_gesture = out_gesture_ff;

endmodule

FILE: bench/touch_gesture_classifier_tb.sv
// Self-checking bench for touch_gesture_classifier: directed and random tap, long press and swipe
// sequences go through the valid/stall channels and are checked against an in-bench predictor.
// Depends on tgc_pkg and the touch_gesture_classifier RTL.
`timescale 1ns / 1ps

module touch_gesture_classifier_tb;
   import tgc_pkg::*;

   localparam int POS_W       = 11;
   localparam int POS_MAX     = (1 << POS_W) - 1;
   localparam int IDLE_PCT    = 12;
   localparam int QUIET_LO    = 500;
   localparam int QUIET_HI    = 700;
   localparam int PHASE_ITEMS = 135;
   localparam int DRAIN_CYCLES = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic              touching;
      logic [TIME_W-1:0] time_ms;
      logic [POS_W-1:0]  pos_x;
   } touch_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_touching = 1'b0;
   logic [TIME_W-1:0]     req_time_ms = '0;
   logic [POS_W-1:0]      req_pos_x = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_gesture;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   touch_sample_type pending_samples[$];
   gesture_type      expected_gestures[$];

   logic [THR_W-1:0]  thr_px  = 11'd40;
   logic [LONG_W-1:0] long_ms = 16'd600;

   logic              press_held  = 1'b0;
   logic [TIME_W-1:0] press_t0    = '0;
   logic              long_seen   = 1'b0;
   logic [POS_W-1:0]  press_x0    = '0;
   logic              moved       = 1'b0;

   int accepted_samples = 0;
   int accepted_gestures = 0;
   int errors = 0;
   int idle_cycles = 0;

   touch_gesture_classifier #(.POS_BITS(POS_W)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_touching(req_touching),
      .req_time_ms (req_time_ms),
      .req_pos_x   (req_pos_x),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_gesture (rsp_gesture),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the press state by one sample and return the gesture it reports.
   function automatic gesture_type classify_sample(input touch_sample_type s);
      int signed   offs;
      int signed   mag;
      int signed   thr;
      logic [31:0] elapsed;
      gesture_type g;
      offs    = int'(s.pos_x) - int'(press_x0);
      mag     = (offs < 0) ? -offs : offs;
      thr     = int'(thr_px);
      elapsed = s.time_ms - press_t0;
      g       = GEST_NONE;
      if (s.touching) begin
         if (!press_held) begin
            press_held = 1'b1;
            press_t0   = s.time_ms;
            long_seen  = 1'b0;
            press_x0   = s.pos_x;
            moved      = 1'b0;
         end else begin
            if (mag >= thr) moved = 1'b1;
            if (!long_seen && elapsed >= 32'(long_ms) && mag < thr) begin
               long_seen = 1'b1;
               g = GEST_LONG;
            end
         end
      end else if (press_held) begin
         if (!long_seen) begin
            if (offs <= -thr) g = GEST_LEFT;
            else if (offs >= thr) g = GEST_RIGHT;
            else if (!moved && elapsed < 32'(long_ms)) g = GEST_TAP;
         end
         press_held = 1'b0;
      end
      return g;
   endfunction

   function automatic logic quiet_window(input int count);
      return count >= QUIET_LO && count < QUIET_HI;
   endfunction

   always @(posedge clock) begin : drive
      touch_sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_gestures.push_back(classify_sample({req_touching, req_time_ms, req_pos_x}));
            accepted_samples++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 &&
                (quiet_window(accepted_samples) || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = pending_samples.pop_front();
               req_valid    <= 1'b1;
               req_touching <= nxt.touching;
               req_time_ms  <= nxt.time_ms;
               req_pos_x    <= nxt.pos_x;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      gesture_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         accepted_gestures++;
         if (expected_gestures.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected gesture %0d with nothing pending", rsp_gesture);
         end else begin
            want = expected_gestures.pop_front();
            if (rsp_gesture !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("gesture mismatch at gesture %0d: expected %0d, got %0d",
                           accepted_gestures, want, rsp_gesture);
            end
         end
      end
      rsp_stall <= !quiet_window(accepted_gestures) && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("touch_gesture_classifier_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_sample(input logic touching, input logic [31:0] t, input int x);
      pending_samples.push_back({touching, t, POS_W'(x)});
   endtask

   task automatic csr_write(input csr_reg_type r, input logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         REG_SWIPE_THRESHOLD: thr_px  = v[THR_W-1:0];
         REG_LONG_PRESS:      long_ms = v[LONG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_valid || expected_gestures.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_elapsed();
      logic [31:0] lm;
      lm = 32'(long_ms);
      case ($urandom_range(0, 5))
         0:       return (lm == 0) ? 32'd0 : $urandom_range(0, lm - 1);
         1:       return lm;
         2:       return (lm == 0) ? 32'd0 : lm - 1;
         3:       return lm + $urandom_range(1, 300);
         4:       return $urandom_range(0, 50);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_pos(input int x0);
      int thr;
      int d;
      int x;
      thr = int'(thr_px);
      case ($urandom_range(0, 6))
         0:       d = 0;
         1:       d = thr;
         2:       d = -thr;
         3:       d = thr - 1;
         4:       d = 1 - thr;
         5:       d = int'($urandom_range(0, 2 * thr)) - thr;
         default: return $urandom_range(0, POS_MAX);
      endcase
      x = x0 + d;
      if (x < 0 || x > POS_MAX) x = $urandom_range(0, POS_MAX);
      return x;
   endfunction

   task automatic make_gesture();
      logic [31:0] t0;
      int          x0;
      int          n;
      t0 = $urandom;
      x0 = $urandom_range(0, POS_MAX);
      n  = $urandom_range(0, 4);
      push_sample(1'b1, t0, x0);
      repeat (n) push_sample(1'b1, t0 + pick_elapsed(), pick_pos(x0));
      if ($urandom_range(0, 9) != 0) push_sample(1'b0, t0 + pick_elapsed(), pick_pos(x0));
   endtask

   task automatic fill_random_phase();
      int start;
      start = pending_samples.size();
      while (pending_samples.size() - start < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 85)
            make_gesture();
         else
            push_sample(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, POS_MAX));
      end
   endtask

   task automatic run_phase(input logic [31:0] thr, input logic [31:0] lp);
      csr_write(REG_SWIPE_THRESHOLD, thr);
      csr_write(REG_LONG_PRESS, lp);
      fill_random_phase();
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // release while idle, extremes of every field
      push_sample(1'b0, 32'hFFFF_FFFF, POS_MAX);
      // tap across the timestamp wrap
      push_sample(1'b1, 32'hFFFF_FF00, 0);
      push_sample(1'b0, 32'h0000_0010, 0);
      // swipe left at exactly the threshold
      push_sample(1'b1, 32'd0, POS_MAX);
      push_sample(1'b0, 32'd5, POS_MAX - 40);
      // swipe right at exactly the threshold
      push_sample(1'b1, 32'd1000, 1000);
      push_sample(1'b0, 32'd1010, 1040);
      // moved then returned: no tap
      push_sample(1'b1, 32'd100, 0);
      push_sample(1'b1, 32'd110, 40);
      push_sample(1'b0, 32'd120, 0);
      // long press fires once, release reports nothing
      push_sample(1'b1, 32'd5000, 1000);
      push_sample(1'b1, 32'd5600, 1000);
      push_sample(1'b1, 32'd5700, 1039);
      push_sample(1'b0, 32'd5800, 1000);
      // just short of both limits: tap
      push_sample(1'b1, 32'd7000, 500);
      push_sample(1'b1, 32'd7599, 539);
      push_sample(1'b0, 32'd7599, 461);
      // release at the long press time without a long press: nothing
      push_sample(1'b1, 32'h8000_0000, 300);
      push_sample(1'b0, 32'h8000_0258, 300);
      // moved by the threshold after the limit: no long press
      push_sample(1'b1, 32'h7FFF_FFFF, 1024);
      push_sample(1'b1, 32'h8000_0300, 984);
      push_sample(1'b0, 32'h8000_0301, 1024);
      drain();

      run_phase(32'd0, 32'd0);
      run_phase(32'd2047, 32'd65535);
      run_phase(32'd0, 32'd65535);
      run_phase(32'd2047, 32'd0);
      repeat (3) run_phase($urandom_range(1, 300), $urandom_range(1, 3000));
      run_phase(32'd40, 32'd600);

      if (errors == 0)
         $display("touch_gesture_classifier_tb: clean");
      else
         $display("touch_gesture_classifier_tb: errors");
      $finish;
   end

endmodule
